// ===== rtl/bmsi_pkg.sv =====
// shared types, register offsets and constants of the scanline irq bank mapper
`default_nettype none
package bmsi_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_PRG   = 2'd1,
        REQ_CHR   = 2'd2,
        REQ_TICK  = 2'd3
    } req_type_t;

    // register file offsets
    localparam logic [3:0] PRG_BLOCK_IDX = 4'h0;
    localparam logic [3:0] PRG_SLOT0_IDX = 4'h7;
    localparam logic [3:0] PRG_SLOT1_IDX = 4'h8;
    localparam logic [3:0] PRG_SLOT2_IDX = 4'h9;
    localparam logic [3:0] PRG_OUTER_IDX = 4'hA;
    localparam logic [3:0] PRG_MODE_IDX  = 4'hB;
    localparam logic [3:0] CHR_BLOCK_IDX = 4'h8;
    localparam logic [3:0] CHR_MASK_IDX  = 4'hA;

    // $4100 window aliases of the irq registers
    localparam logic [3:0] ALT_LATCH   = 4'h1;
    localparam logic [3:0] ALT_RELOAD  = 4'h2;
    localparam logic [3:0] ALT_DISABLE = 4'h3;
    localparam logic [3:0] ALT_ENABLE  = 4'h4;

    // {addr[15:13], addr[0]} codes of the command/data window
    localparam logic [3:0] HI_COMMAND = 4'b1000;
    localparam logic [3:0] HI_DATA    = 4'b1001;
    localparam logic [3:0] HI_MIRROR  = 4'b1010;
    localparam logic [3:0] HI_LATCH   = 4'b1100;
    localparam logic [3:0] HI_RELOAD  = 4'b1101;
    localparam logic [3:0] HI_DISABLE = 4'b1110;
    localparam logic [3:0] HI_ENABLE  = 4'b1111;

    localparam logic [11:0] CHR_WIN_HI = 12'h201;
    localparam logic [11:0] ALT_WIN_HI = 12'h410;

    localparam logic [7:0] CMD_KEEP_MASK  = 8'h38;
    localparam logic [7:0] CMD_WRITE_MASK = 8'hC7;
    localparam logic [7:0] LATCH_MASK     = 8'hFE;
    localparam logic [7:0] PRG_BASE_MASK  = 8'h3F;
    localparam logic [7:0] FULL_MASK      = 8'hFF;
    localparam logic [7:0] PRG_FIXED_2ND  = 8'hFE;
    localparam logic [7:0] PRG_FIXED_LAST = 8'hFF;
    localparam logic [8:0] VISIBLE_LAST   = 9'd239;

    typedef struct packed {
        logic [15:0][7:0] prg;
        logic [15:0][7:0] chr;
        logic [7:0]       command;
    } bank_view_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        display_on;
    } req_item_t;

    typedef struct packed {
        logic [11:0] prg_bank;
        logic [14:0] chr_bank;
        logic        mirror_horizontal;
        logic        irq_line;
    } rsp_item_t;

    function automatic logic [2:0] chr_mask_shift(input logic [2:0] mode);
        logic [2:0] s;
        case (mode)
            3'd0:    s = 3'd0;
            3'd1:    s = 3'd1;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd0;
            3'd4:    s = 3'd3;
            3'd5:    s = 3'd4;
            3'd6:    s = 3'd5;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // register targeted by a data write, selected by command bits 2:0
    function automatic logic [3:0] data_target(input logic [2:0] sel);
        logic [3:0] t;
        case (sel)
            3'd0:    t = 4'd6;
            3'd1:    t = 4'd7;
            3'd2:    t = 4'd2;
            3'd3:    t = 4'd3;
            3'd4:    t = 4'd4;
            3'd5:    t = 4'd5;
            3'd6:    t = PRG_SLOT0_IDX;
            default: t = PRG_SLOT1_IDX;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bmsi_req_if.sv =====
// request channel: one bus access or scanline tick per transfer
`default_nettype none
interface bmsi_req_if
    import bmsi_pkg::*;
();
    logic        valid;
    logic        ready;
    req_type_t   req_type;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        display_on;

    modport source (output valid, req_type, addr, data, scanline, display_on, input ready);
    modport sink   (input valid, req_type, addr, data, scanline, display_on, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmsi_rsp_if.sv =====
// result channel: translated banks, mirroring and irq level per transfer
`default_nettype none
interface bmsi_rsp_if
    import bmsi_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [11:0] prg_bank;
    logic [14:0] chr_bank;
    logic        mirror_horizontal;
    logic        irq_line;

    modport source (output valid, prg_bank, chr_bank, mirror_horizontal, irq_line, input ready);
    modport sink   (input valid, prg_bank, chr_bank, mirror_horizontal, irq_line, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmsi_xlate.sv =====
// program and pattern bank translation from the current register view
`default_nettype none
module bmsi_xlate
    import bmsi_pkg::*;
(
    input  bank_view_t  view,
    input  logic [15:0] addr,
    output logic [11:0] prg_bank,
    output logic [14:0] chr_bank
);
    logic [2:0]  prg_mode;
    logic [7:0]  prg_mask;
    logic [11:0] prg_block;
    logic [1:0]  prg_slot;
    logic [7:0]  prg_sel;
    logic [7:0]  chr_mask;
    logic [14:0] chr_block;
    logic [2:0]  chr_slot;
    logic [7:0]  chr_sel;

    always_comb
    begin
        prg_mode  = view.prg[PRG_MODE_IDX][2:0];
        prg_mask  = (prg_mode == 3'd7) ? FULL_MASK : (PRG_BASE_MASK >> prg_mode);
        prg_block = {view.prg[PRG_BLOCK_IDX][7:4], view.prg[PRG_OUTER_IDX] & ~prg_mask};
        prg_slot  = addr[14:13];
        // swap bit exchanges the first and third slots ($8000 and $C000)
        if (view.command[6] && !prg_slot[0])
            prg_slot = prg_slot ^ 2'd2;
        case (prg_slot)
            2'd0:    prg_sel = view.prg[PRG_SLOT0_IDX];
            2'd1:    prg_sel = view.prg[PRG_SLOT1_IDX];
            2'd2:    prg_sel = view.prg[PRG_MODE_IDX][6] ? view.prg[PRG_SLOT2_IDX]
                                                         : PRG_FIXED_2ND;
            default: prg_sel = PRG_FIXED_LAST;
        endcase
        // nothing is mapped below $8000
        prg_bank = addr[15] ? (prg_block | {4'd0, prg_sel & prg_mask}) : 12'd0;

        chr_mask  = FULL_MASK >> chr_mask_shift(view.chr[CHR_MASK_IDX][2:0]);
        chr_block = {view.prg[PRG_BLOCK_IDX][3:0], view.chr[CHR_BLOCK_IDX][6:4],
                     view.chr[CHR_MASK_IDX] & ~chr_mask};
        chr_slot  = addr[12:10] ^ {view.command[7], 2'b00};
        case (chr_slot)
            3'd0:    chr_sel = view.chr[6] & 8'hFE;
            3'd1:    chr_sel = view.chr[6] | 8'h01;
            3'd2:    chr_sel = view.chr[7] & 8'hFE;
            3'd3:    chr_sel = view.chr[7] | 8'h01;
            3'd4:    chr_sel = view.chr[2];
            3'd5:    chr_sel = view.chr[3];
            3'd6:    chr_sel = view.chr[4];
            default: chr_sel = view.chr[5];
        endcase
        // only the pattern area below $2000 translates
        chr_bank = (addr[15:13] == 3'd0) ? (chr_block | {7'd0, chr_sel & chr_mask}) : 15'd0;
    end
endmodule
`default_nettype wire

// ===== rtl/bank_mapper_scanline_irq.sv =====
// Cartridge bank mapper with scanline interrupt counter, top level.
// The req channel carries one item per transfer: a CPU register write, a CPU
// program translate, a video pattern translate or a scanline tick, chosen by
// req_type. The rsp channel returns exactly one result per item, in order:
// program bank, pattern bank, mirroring and the irq level after that item.
// An accepted item sits in the input register, where the register files are
// read and updated, and its result is then held in the output register,
// which offers it on rsp. One item is taken every cycle while the receiver
// keeps up. When the receiver stalls, the output register holds its result,
// the input register holds one more item and req.ready then drops until
// rsp moves. Reset clears all register files, the irq counter and its flags,
// and empties both pipeline registers; items are accepted from the first
// cycle after it.
`default_nettype none
module bank_mapper_scanline_irq
    import bmsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bmsi_req_if.sink    req,
    bmsi_rsp_if.source  rsp
);
    logic             s1_valid_reg;
    req_item_t        s1_item_reg;
    logic             out_valid_reg;
    rsp_item_t        out_item_reg;
    rsp_item_t        out_item_next;
    logic             advance;

    logic [15:0][7:0] prg_regs_reg, prg_regs_next;
    logic [15:0][7:0] chr_regs_reg, chr_regs_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       mirror_reg, mirror_next;
    logic [7:0]       latch_reg, latch_next;
    logic [7:0]       counter_reg, counter_next;
    logic             reload_reg, reload_next;
    logic             enable_reg, enable_next;
    logic             pending_reg, pending_next;

    bank_view_t       view;
    logic [11:0]      xl_prg;
    logic [14:0]      xl_chr;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;

    assign view = '{prg: prg_regs_reg, chr: chr_regs_reg, command: command_reg};

    bmsi_xlate u_xlate (
        .view     (view),
        .addr     (s1_item_reg.addr),
        .prg_bank (xl_prg),
        .chr_bank (xl_chr)
    );

    always_comb
    begin
        prg_regs_next = prg_regs_reg;
        chr_regs_next = chr_regs_reg;
        command_next  = command_reg;
        mirror_next   = mirror_reg;
        latch_next    = latch_reg;
        counter_next  = counter_reg;
        reload_next   = reload_reg;
        enable_next   = enable_reg;
        pending_next  = pending_reg;

        case (s1_item_reg.req_type)
            REQ_WRITE:
            begin
                if (s1_item_reg.addr[15:4] == CHR_WIN_HI)
                begin
                    chr_regs_next[s1_item_reg.addr[3:0]] = s1_item_reg.data;
                end
                else if (s1_item_reg.addr[15:4] == ALT_WIN_HI)
                begin
                    case (s1_item_reg.addr[3:0])
                        ALT_LATCH:   latch_next = s1_item_reg.data & LATCH_MASK;
                        ALT_RELOAD:  reload_next = 1'b1;
                        ALT_DISABLE:
                        begin
                            enable_next  = 1'b0;
                            pending_next = 1'b0;
                        end
                        ALT_ENABLE:  enable_next = 1'b1;
                        default:     prg_regs_next[s1_item_reg.addr[3:0]] = s1_item_reg.data;
                    endcase
                end
                else if (s1_item_reg.addr[15])
                begin
                    case ({s1_item_reg.addr[15:13], s1_item_reg.addr[0]})
                        HI_COMMAND:
                            command_next = (command_reg & CMD_KEEP_MASK)
                                         | (s1_item_reg.data & CMD_WRITE_MASK);
                        HI_DATA:
                        begin
                            if (command_reg[2:1] == 2'b11)
                                prg_regs_next[data_target(command_reg[2:0])] = s1_item_reg.data;
                            else
                                chr_regs_next[data_target(command_reg[2:0])] = s1_item_reg.data;
                        end
                        HI_MIRROR:  mirror_next = s1_item_reg.data;
                        HI_LATCH:   latch_next = s1_item_reg.data & LATCH_MASK;
                        HI_RELOAD:  reload_next = 1'b1;
                        HI_DISABLE:
                        begin
                            enable_next  = 1'b0;
                            pending_next = 1'b0;
                        end
                        HI_ENABLE:  enable_next = 1'b1;
                        default:    ;
                    endcase
                end
            end
            REQ_TICK:
            begin
                // counts only on visible lines with rendering enabled
                if (s1_item_reg.scanline <= VISIBLE_LAST && s1_item_reg.display_on)
                begin
                    if (counter_reg == 8'd0 || reload_reg)
                    begin
                        counter_next = latch_reg;
                        reload_next  = 1'b0;
                    end
                    else
                    begin
                        counter_next = counter_reg - 8'd1;
                    end
                    if (counter_reg != 8'd0 && counter_next == 8'd0 && enable_reg)
                        pending_next = 1'b1;
                end
            end
            default: ;
        endcase

        out_item_next.prg_bank          = (s1_item_reg.req_type == REQ_PRG) ? xl_prg : 12'd0;
        out_item_next.chr_bank          = (s1_item_reg.req_type == REQ_CHR) ? xl_chr : 15'd0;
        out_item_next.mirror_horizontal = mirror_next[0];
        out_item_next.irq_line          = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prg_regs_reg  <= '0;
            chr_regs_reg  <= '0;
            command_reg   <= '0;
            mirror_reg    <= '0;
            latch_reg     <= '0;
            counter_reg   <= '0;
            reload_reg    <= 1'b0;
            enable_reg    <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (s1_valid_reg && advance)
            begin
                prg_regs_reg  <= prg_regs_next;
                chr_regs_reg  <= chr_regs_next;
                command_reg   <= command_next;
                mirror_reg    <= mirror_next;
                latch_reg     <= latch_next;
                counter_reg   <= counter_next;
                reload_reg    <= reload_next;
                enable_reg    <= enable_next;
                pending_reg   <= pending_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg.req_type   <= req.req_type;
            s1_item_reg.addr       <= req.addr;
            s1_item_reg.data       <= req.data;
            s1_item_reg.scanline   <= req.scanline;
            s1_item_reg.display_on <= req.display_on;
        end
        if (s1_valid_reg && advance)
            out_item_reg <= out_item_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.prg_bank          = out_item_reg.prg_bank;
    assign rsp.chr_bank          = out_item_reg.chr_bank;
    assign rsp.mirror_horizontal = out_item_reg.mirror_horizontal;
    assign rsp.irq_line          = out_item_reg.irq_line;

    // mapper state must not move while the held item waits on a stalled output
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> $stable(counter_reg) && $stable(pending_reg)
                                     && $stable(prg_regs_reg) && $stable(chr_regs_reg))
        else $error("mapper state changed during output stall");

    // the irq level can only be raised by a scanline tick
    a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pending_reg) |-> $past(s1_valid_reg && advance)
                               && $past(s1_item_reg.req_type) == REQ_TICK)
        else $error("irq raised by a non-tick item");

    // a disabled counter never leaves a request pending
    a_irq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        !enable_reg |-> !pending_reg)
        else $error("irq pending while disabled");

    // the counter only moves on a tick leaving the input register
    a_counter_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(counter_reg) |-> $past(s1_valid_reg && advance)
                                  && $past(s1_item_reg.req_type) == REQ_TICK)
        else $error("irq counter moved outside a tick");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the scanline irq bank mapper
`timescale 1ns / 1ps
module tb;
    import bmsi_pkg::*;

    // pattern registers reached through the data window
    localparam logic [3:0] CHR_PAIR0_IDX = 4'h6;
    localparam logic [3:0] CHR_PAIR1_IDX = 4'h7;
    localparam logic [3:0] CHR_ONE0_IDX  = 4'h2;
    localparam logic [3:0] CHR_ONE1_IDX  = 4'h3;
    localparam logic [3:0] CHR_ONE2_IDX  = 4'h4;
    localparam logic [3:0] CHR_ONE3_IDX  = 4'h5;

    localparam int unsigned RANDOM_ITEMS = 1950;

    logic clk;
    logic rst_n;

    bmsi_req_if req_bus ();
    bmsi_rsp_if rsp_bus ();

    bank_mapper_scanline_irq u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // mapper state as predicted from the accepted requests
    logic [7:0] prg_file [16];
    logic [7:0] chr_file [16];
    logic [7:0] cmd_reg;
    logic [7:0] mir_reg;
    logic [7:0] irq_latch;
    logic [7:0] irq_count;
    bit         irq_reload;
    bit         irq_en;
    bit         irq_pend;

    req_item_t   pending_q [$];
    rsp_item_t   expected_q [$];
    req_item_t   on_bus;
    req_item_t   next_req;
    rsp_item_t   want;
    int unsigned req_gap;
    int unsigned stall_left;
    bit          req_calm;
    bit          rsp_calm;
    int unsigned n_fail;
    int unsigned n_useful;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // updates the predicted state and returns the result of one request
    function automatic rsp_item_t predict_mapper(input req_item_t it);
        rsp_item_t  res;
        logic [2:0] mode;
        logic [2:0] shift;
        logic [7:0] mask;
        logic [7:0] bank;
        logic [1:0] pslot;
        logic [2:0] cslot;
        logic [7:0] prev;
        res = '0;
        case (it.req_type)
            REQ_WRITE:
            begin
                if (it.addr[15:4] == CHR_WIN_HI)
                    chr_file[it.addr[3:0]] = it.data;
                else if (it.addr[15:4] == ALT_WIN_HI)
                begin
                    case (it.addr[3:0])
                        ALT_LATCH:   irq_latch = it.data & LATCH_MASK;
                        ALT_RELOAD:  irq_reload = 1'b1;
                        ALT_DISABLE:
                        begin
                            irq_en = 1'b0;
                            irq_pend = 1'b0;
                        end
                        ALT_ENABLE:  irq_en = 1'b1;
                        default:     prg_file[it.addr[3:0]] = it.data;
                    endcase
                end
                else if (it.addr[15])
                begin
                    case ({it.addr[15:13], it.addr[0]})
                        HI_COMMAND:
                            cmd_reg = (cmd_reg & CMD_KEEP_MASK) | (it.data & CMD_WRITE_MASK);
                        HI_DATA:
                        begin
                            case (cmd_reg[2:0])
                                3'd0:    chr_file[CHR_PAIR0_IDX] = it.data;
                                3'd1:    chr_file[CHR_PAIR1_IDX] = it.data;
                                3'd2:    chr_file[CHR_ONE0_IDX] = it.data;
                                3'd3:    chr_file[CHR_ONE1_IDX] = it.data;
                                3'd4:    chr_file[CHR_ONE2_IDX] = it.data;
                                3'd5:    chr_file[CHR_ONE3_IDX] = it.data;
                                3'd6:    prg_file[PRG_SLOT0_IDX] = it.data;
                                default: prg_file[PRG_SLOT1_IDX] = it.data;
                            endcase
                        end
                        HI_MIRROR:  mir_reg = it.data;
                        HI_LATCH:   irq_latch = it.data & LATCH_MASK;
                        HI_RELOAD:  irq_reload = 1'b1;
                        HI_DISABLE:
                        begin
                            irq_en = 1'b0;
                            irq_pend = 1'b0;
                        end
                        HI_ENABLE:  irq_en = 1'b1;
                        default:    ;
                    endcase
                end
            end
            REQ_PRG:
            begin
                // nothing is mapped below $8000
                if (it.addr[15])
                begin
                    mode = prg_file[PRG_MODE_IDX][2:0];
                    mask = (mode == 3'd7) ? FULL_MASK : (PRG_BASE_MASK >> mode);
                    pslot = it.addr[14:13];
                    if (cmd_reg[6] && !pslot[0])
                        pslot = pslot ^ 2'b10;
                    case (pslot)
                        2'd0:    bank = prg_file[PRG_SLOT0_IDX];
                        2'd1:    bank = prg_file[PRG_SLOT1_IDX];
                        2'd2:    bank = prg_file[PRG_MODE_IDX][6] ? prg_file[PRG_SLOT2_IDX]
                                                                  : PRG_FIXED_2ND;
                        default: bank = PRG_FIXED_LAST;
                    endcase
                    res.prg_bank = {prg_file[PRG_BLOCK_IDX][7:4],
                                    (prg_file[PRG_OUTER_IDX] & ~mask) | (bank & mask)};
                end
            end
            REQ_CHR:
            begin
                // pattern area only
                if (it.addr[15:13] == 3'b000)
                begin
                    case (chr_file[CHR_MASK_IDX][2:0])
                        3'd1:    shift = 3'd1;
                        3'd2:    shift = 3'd2;
                        3'd4:    shift = 3'd3;
                        3'd5:    shift = 3'd4;
                        3'd6:    shift = 3'd5;
                        default: shift = 3'd0;
                    endcase
                    mask = FULL_MASK >> shift;
                    cslot = it.addr[12:10];
                    if (cmd_reg[7])
                        cslot = cslot ^ 3'b100;
                    case (cslot)
                        3'd0:    bank = {chr_file[CHR_PAIR0_IDX][7:1], 1'b0};
                        3'd1:    bank = {chr_file[CHR_PAIR0_IDX][7:1], 1'b1};
                        3'd2:    bank = {chr_file[CHR_PAIR1_IDX][7:1], 1'b0};
                        3'd3:    bank = {chr_file[CHR_PAIR1_IDX][7:1], 1'b1};
                        3'd4:    bank = chr_file[CHR_ONE0_IDX];
                        3'd5:    bank = chr_file[CHR_ONE1_IDX];
                        3'd6:    bank = chr_file[CHR_ONE2_IDX];
                        default: bank = chr_file[CHR_ONE3_IDX];
                    endcase
                    res.chr_bank = {prg_file[PRG_BLOCK_IDX][3:0], chr_file[CHR_BLOCK_IDX][6:4],
                                    (chr_file[CHR_MASK_IDX] & ~mask) | (bank & mask)};
                end
            end
            default:
            begin
                if (it.scanline <= VISIBLE_LAST && it.display_on)
                begin
                    prev = irq_count;
                    if (prev == 8'd0 || irq_reload)
                    begin
                        irq_count = irq_latch;
                        irq_reload = 1'b0;
                    end
                    else
                        irq_count = prev - 8'd1;
                    if (prev != 8'd0 && irq_count == 8'd0 && irq_en)
                        irq_pend = 1'b1;
                end
            end
        endcase
        res.mirror_horizontal = mir_reg[0];
        res.irq_line = irq_pend;
        return res;
    endfunction

    task automatic add_req(input req_type_t t, input logic [15:0] a, input logic [7:0] d,
                           input logic [8:0] line, input logic disp);
        req_item_t it;
        it.req_type = t;
        it.addr = a;
        it.data = d;
        it.scanline = line;
        it.display_on = disp;
        pending_q.push_back(it);
    endtask

    task automatic add_write(input logic [15:0] a, input logic [7:0] d);
        add_req(REQ_WRITE, a, d, 9'($urandom_range(0, 261)), 1'($urandom));
    endtask

    task automatic add_prg(input logic [15:0] a);
        add_req(REQ_PRG, a, 8'($urandom), 9'($urandom_range(0, 261)), 1'($urandom));
    endtask

    task automatic add_chr(input logic [15:0] a);
        add_req(REQ_CHR, a, 8'($urandom), 9'($urandom_range(0, 261)), 1'($urandom));
    endtask

    task automatic add_tick(input logic [8:0] line, input logic disp);
        add_req(REQ_TICK, 16'($urandom), 8'($urandom), line, disp);
    endtask

    // any address of the command/data window that decodes to the given code
    function automatic logic [15:0] hi_addr(input logic [3:0] code);
        logic [11:0] mid;
        mid = 12'($urandom);
        return {code[3:1], mid, code[0]};
    endfunction

    task automatic add_translates(input int unsigned n);
        logic [15:0] a;
        repeat (n)
        begin
            if ($urandom_range(0, 1))
            begin
                a = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(16'h8000, 16'hFFFF))
                                                 : 16'($urandom);
                add_prg(a);
            end
            else
            begin
                a = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 16'h1FFF))
                                                 : 16'($urandom);
                add_chr(a);
            end
            n_useful++;
        end
    endtask

    task automatic add_setup();
        logic [3:0] code;
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 5))
                0: add_write({CHR_WIN_HI, 4'($urandom)}, 8'($urandom));
                1: add_write({ALT_WIN_HI, 4'($urandom)}, 8'($urandom));
                2:
                begin
                    add_write(hi_addr(HI_COMMAND), 8'($urandom));
                    add_write(hi_addr(HI_DATA), 8'($urandom));
                    n_useful++;
                end
                3: add_write(hi_addr(HI_MIRROR), 8'($urandom));
                4: add_write(hi_addr(HI_DATA), 8'($urandom));
                default:
                begin
                    // the rest of the window, the ignored odd mirror address among it
                    code = {1'b1, 3'($urandom)};
                    add_write(hi_addr(code), 8'($urandom));
                end
            endcase
            n_useful++;
        end
    endtask

    task automatic add_frame();
        int unsigned first;
        int unsigned count;
        int unsigned line;
        logic [7:0]  latch;
        latch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6) * 2);
        if ($urandom_range(0, 1))
            add_write(hi_addr(HI_LATCH), latch);
        else
            add_write({ALT_WIN_HI, ALT_LATCH}, latch);
        if ($urandom_range(0, 3) != 0)
            add_write($urandom_range(0, 1) ? hi_addr(HI_RELOAD) : {ALT_WIN_HI, ALT_RELOAD},
                      8'($urandom));
        if ($urandom_range(0, 4) == 0)
            add_write($urandom_range(0, 1) ? hi_addr(HI_DISABLE) : {ALT_WIN_HI, ALT_DISABLE},
                      8'($urandom));
        else
            add_write($urandom_range(0, 1) ? hi_addr(HI_ENABLE) : {ALT_WIN_HI, ALT_ENABLE},
                      8'($urandom));
        n_useful += 3;
        first = $urandom_range(0, 245);
        count = $urandom_range(3, 20);
        for (int unsigned i = 0; i < count; i++)
        begin
            line = first + i;
            if (line > 261)
                break;
            add_tick(9'(line), ($urandom_range(0, 9) != 0));
            n_useful++;
            if ($urandom_range(0, 4) == 0)
                add_translates(1);
            if ($urandom_range(0, 14) == 0)
            begin
                // acknowledge mid frame
                add_write(hi_addr(HI_DISABLE), 8'($urandom));
                add_write(hi_addr(HI_ENABLE), 8'($urandom));
                n_useful += 2;
            end
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 3))
            add_req(req_type_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                    9'($urandom_range(0, 261)), 1'($urandom));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid      <= 1'b0;
            req_bus.req_type   <= REQ_WRITE;
            req_bus.addr       <= '0;
            req_bus.data       <= '0;
            req_bus.scanline   <= '0;
            req_bus.display_on <= 1'b0;
            req_gap = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                on_bus.req_type   = req_bus.req_type;
                on_bus.addr       = req_bus.addr;
                on_bus.data       = req_bus.data;
                on_bus.scanline   = req_bus.scanline;
                on_bus.display_on = req_bus.display_on;
                expected_q.push_back(predict_mapper(on_bus));
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (req_gap == 0 && pending_q.size() != 0)
                begin
                    next_req = pending_q.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.req_type   <= next_req.req_type;
                    req_bus.addr       <= next_req.addr;
                    req_bus.data       <= next_req.data;
                    req_bus.scanline   <= next_req.scanline;
                    req_bus.display_on <= next_req.display_on;
                    if ($urandom_range(0, 149) == 0)
                        req_calm = !req_calm;
                    req_gap = pick_gap(req_calm);
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                    if (req_gap != 0)
                        req_gap--;
                end
            end
        end
    end

    // result monitor and ready driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no request outstanding: prg_bank %0h chr_bank %0h",
                           rsp_bus.prg_bank, rsp_bus.chr_bank);
                    n_fail++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp_bus.prg_bank !== want.prg_bank)
                    begin
                        $error("prg_bank: expected %0h, actual %0h", want.prg_bank,
                               rsp_bus.prg_bank);
                        n_fail++;
                    end
                    if (rsp_bus.chr_bank !== want.chr_bank)
                    begin
                        $error("chr_bank: expected %0h, actual %0h", want.chr_bank,
                               rsp_bus.chr_bank);
                        n_fail++;
                    end
                    if (rsp_bus.mirror_horizontal !== want.mirror_horizontal)
                    begin
                        $error("mirror_horizontal: expected %0b, actual %0b",
                               want.mirror_horizontal, rsp_bus.mirror_horizontal);
                        n_fail++;
                    end
                    if (rsp_bus.irq_line !== want.irq_line)
                    begin
                        $error("irq_line: expected %0b, actual %0b", want.irq_line,
                               rsp_bus.irq_line);
                        n_fail++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                rsp_calm = !rsp_calm;
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(rsp_calm);
            end
        end
    end

    initial
    begin
        #1_500_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_WRITE;
        req_bus.addr = '0;
        req_bus.data = '0;
        req_bus.scanline = '0;
        req_bus.display_on = 1'b0;
        rsp_bus.ready = 1'b0;
        foreach (prg_file[i])
        begin
            prg_file[i] = '0;
            chr_file[i] = '0;
        end
        cmd_reg = '0;
        mir_reg = '0;
        irq_latch = '0;
        irq_count = '0;
        irq_reload = 1'b0;
        irq_en = 1'b0;
        irq_pend = 1'b0;
        n_fail = 0;
        n_useful = 0;
        req_calm = 1'b0;
        rsp_calm = 1'b0;

        // directed: translates straight out of reset and outside their windows
        add_prg(16'hFFFF);
        add_prg(16'h7FFF);
        add_chr(16'h0000);
        add_chr(16'h2000);
        // outer block, fixed mask mode with the third slot switchable, both swaps
        add_write({ALT_WIN_HI, PRG_BLOCK_IDX}, 8'hF3);
        add_write({ALT_WIN_HI, PRG_MODE_IDX}, 8'h47);
        add_write({ALT_WIN_HI, PRG_OUTER_IDX}, 8'hFF);
        add_write(16'h8000, 8'hFF);
        add_write(16'h9FFF, 8'hAB);
        add_write({CHR_WIN_HI, CHR_BLOCK_IDX}, 8'h7F);
        add_write({CHR_WIN_HI, CHR_MASK_IDX}, 8'h06);
        add_prg(16'h8000);
        add_prg(16'hC000);
        add_chr(16'h1FFF);
        add_chr(16'h0400);
        // mirroring, then writes that must be dropped
        add_write(16'hA000, 8'hFF);
        add_write(16'hA001, 8'h00);
        add_write(16'h3000, 8'hFF);
        // counter: reload to two, ignored ticks off screen and with display off
        add_write(16'hC000, 8'h03);
        add_write(16'hC001, 8'h00);
        add_write(16'hE001, 8'h00);
        add_tick(9'd0, 1'b1);
        add_tick(9'd240, 1'b1);
        add_tick(9'd5, 1'b0);
        add_tick(9'd239, 1'b1);
        add_tick(9'd1, 1'b1);
        add_write({ALT_WIN_HI, ALT_DISABLE}, 8'h00);
        add_write({ALT_WIN_HI, ALT_LATCH}, 8'hFF);
        add_write({ALT_WIN_HI, ALT_RELOAD}, 8'h00);
        add_write({ALT_WIN_HI, ALT_ENABLE}, 8'h00);
        add_tick(9'd261, 1'b1);

        while (n_useful < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_setup();
                3, 4, 5: add_translates($urandom_range(1, 6));
                6, 7, 8: add_frame();
                default: add_noise();
            endcase
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        // room for any stray result to show up
        repeat (10) @(posedge clk);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
